/* sv/rvu_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Refraction vector unit package
// Fixed-point widths, the sideband carried past the square root and the
// result record shared by the pipeline modules.
// ----------------------------------------------------------------------------
package rvu_pkg;

  localparam int FRAC_BITS = 14;
  localparam int SQ_STEPS  = 21;

  typedef struct packed {
    logic signed [15:0] nx;
    logic signed [15:0] ny;
    logic signed [15:0] nz;
    logic signed [15:0] ix;
    logic signed [15:0] iy;
    logic signed [15:0] iz;
    logic [15:0]        n;
    logic signed [21:0] nd_fl;
    logic               tir;
  } side_t;

  typedef struct packed {
    logic signed [15:0] tx;
    logic signed [15:0] ty;
    logic signed [15:0] tz;
    logic               tir;
  } result_t;

endpackage

/* sv/rvu_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Refraction vector unit front end
// Six stages: dot product, cosine term, squares, scaling by the squared
// index ratio and the radicand with its total reflection flag.
// ----------------------------------------------------------------------------
module rvu_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  logic signed [15:0] nx_i,
  input  logic signed [15:0] ny_i,
  input  logic signed [15:0] nz_i,
  input  logic signed [15:0] ix_i,
  input  logic signed [15:0] iy_i,
  input  logic signed [15:0] iz_i,
  input  logic [15:0]        n_i,
  output logic               valid_o,
  output logic [40:0]        rad_o,
  output rvu_pkg::side_t     side_o
);
  import rvu_pkg::*;

  logic [5:0] v_q;

  rvu_pkg::side_t s1_side_q, s2_side_q, s3_side_q, s4_side_q, s5_side_q, s6_side_q;
  rvu_pkg::side_t s4_side_d, s6_side_d;
  logic signed [31:0] s1_px_q, s1_py_q, s1_pz_q;
  logic [31:0]        s1_nn_q;
  logic signed [18:0] s2_d_q;
  logic [17:0]        s2_nsq_q, s3_nsq_q, s4_nsq_q;
  logic signed [37:0] s3_dd_q;
  logic signed [35:0] s3_nd_q;
  logic signed [23:0] s4_fu_q;
  logic signed [42:0] s5_p_q;
  logic [40:0]        s6_rad_q;

  logic signed [32:0] dot;
  logic signed [32:0] neg_dot;
  logic signed [37:0] u;
  logic signed [43:0] r;

  always_comb begin
    dot     = s1_px_q + s1_py_q + s1_pz_q;
    neg_dot = -dot;
    u       = (38'sd1 <<< (2 * FRAC_BITS)) - s3_dd_q;
    r       = (44'sd1 <<< (2 * FRAC_BITS)) - s5_p_q;
    s4_side_d       = s3_side_q;
    s4_side_d.nd_fl = 22'(s3_nd_q >>> FRAC_BITS);
    s6_side_d       = s5_side_q;
    s6_side_d.tir   = r[43];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[4:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_px_q          <= nx_i * ix_i;
      s1_py_q          <= ny_i * iy_i;
      s1_pz_q          <= nz_i * iz_i;
      s1_nn_q          <= n_i * n_i;
      s1_side_q.nx     <= nx_i;
      s1_side_q.ny     <= ny_i;
      s1_side_q.nz     <= nz_i;
      s1_side_q.ix     <= ix_i;
      s1_side_q.iy     <= iy_i;
      s1_side_q.iz     <= iz_i;
      s1_side_q.n      <= n_i;
      s1_side_q.nd_fl  <= '0;
      s1_side_q.tir    <= 1'b0;

      s2_d_q           <= 19'(neg_dot >>> FRAC_BITS);
      s2_nsq_q         <= s1_nn_q[31:FRAC_BITS];
      s2_side_q        <= s1_side_q;

      s3_dd_q          <= s2_d_q * s2_d_q;
      s3_nd_q          <= $signed({1'b0, s2_side_q.n}) * s2_d_q;
      s3_nsq_q         <= s2_nsq_q;
      s3_side_q        <= s2_side_q;

      s4_fu_q          <= 24'(u >>> FRAC_BITS);
      s4_nsq_q         <= s3_nsq_q;
      s4_side_q        <= s4_side_d;

      s5_p_q           <= s4_fu_q * $signed({1'b0, s4_nsq_q});
      s5_side_q        <= s4_side_q;

      s6_rad_q         <= r[43] ? '0 : r[40:0];
      s6_side_q        <= s6_side_d;
    end
  end

  assign valid_o = v_q[5];
  assign rad_o   = s6_rad_q;
  assign side_o  = s6_side_q;

endmodule

/* sv/rvu_sqrt.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Refraction vector unit square root
// Restoring integer square root, one result bit per pipeline stage; the
// sideband record travels alongside.
// ----------------------------------------------------------------------------
module rvu_sqrt (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic           valid_i,
  input  logic [40:0]    rad_i,
  input  rvu_pkg::side_t side_i,
  output logic           valid_o,
  output logic [20:0]    root_o,
  output rvu_pkg::side_t side_o
);
  import rvu_pkg::*;

  logic           vld_a  [SQ_STEPS+1];
  logic [40:0]    rem_a  [SQ_STEPS+1];
  logic [41:0]    res_a  [SQ_STEPS+1];
  side_t          side_a [SQ_STEPS+1];

  assign vld_a[0]  = valid_i;
  assign rem_a[0]  = rad_i;
  assign res_a[0]  = '0;
  assign side_a[0] = side_i;

  for (genvar gi = 0; gi < SQ_STEPS; gi++) begin : g_step
    localparam logic [41:0] StepBit = 42'd1 << (2 * (SQ_STEPS - 1 - gi));

    logic [41:0] trial;
    logic [40:0] rem_d;
    logic [41:0] res_d;
    logic        vld_q;
    logic [40:0] rem_q;
    logic [41:0] res_q;
    side_t       side_q;

    always_comb begin
      trial = res_a[gi] + StepBit;
      if ({1'b0, rem_a[gi]} >= trial) begin
        rem_d = rem_a[gi] - trial[40:0];
        res_d = (res_a[gi] >> 1) + StepBit;
      end else begin
        rem_d = rem_a[gi];
        res_d = res_a[gi] >> 1;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q <= 1'b0;
      end else if (en_i) begin
        vld_q <= vld_a[gi];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q  <= rem_d;
        res_q  <= res_d;
        side_q <= side_a[gi];
      end
    end

    assign vld_a[gi+1]  = vld_q;
    assign rem_a[gi+1]  = rem_q;
    assign res_a[gi+1]  = res_q;
    assign side_a[gi+1] = side_q;
  end

  assign valid_o = vld_a[SQ_STEPS];
  assign root_o  = res_a[SQ_STEPS][20:0];
  assign side_o  = side_a[SQ_STEPS];

endmodule

/* sv/rvu_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Refraction vector unit back end
// Three stages: normal scale factor, component products, and the final
// floor, saturation and total reflection zeroing.
// ----------------------------------------------------------------------------
module rvu_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  logic [20:0]      root_i,
  input  rvu_pkg::side_t   side_i,
  output logic             valid_o,
  output rvu_pkg::result_t res_o
);
  import rvu_pkg::*;

  logic [2:0] v_q;

  side_t              b1_side_q, b2_side_q;
  logic signed [22:0] b1_k_q;
  logic signed [38:0] b2_tx_q, b2_ty_q, b2_tz_q;
  logic signed [32:0] b2_mx_q, b2_my_q, b2_mz_q;
  result_t            b3_res_q;

  logic signed [22:0] k_d;
  logic signed [39:0] sum_x, sum_y, sum_z;
  result_t            res_d;

  function automatic logic signed [15:0] sat16(input logic signed [39:0] s);
    logic signed [25:0] f;
    f = 26'(s >>> FRAC_BITS);
    if (f > 26'sd32767) begin
      sat16 = 16'sh7fff;
    end else if (f < -26'sd32768) begin
      sat16 = 16'sh8000;
    end else begin
      sat16 = f[15:0];
    end
  endfunction

  always_comb begin
    k_d   = 23'(side_i.nd_fl) - $signed({2'b00, root_i});
    sum_x = b2_tx_q + b2_mx_q;
    sum_y = b2_ty_q + b2_my_q;
    sum_z = b2_tz_q + b2_mz_q;
    if (b2_side_q.tir) begin
      res_d = '{tx: '0, ty: '0, tz: '0, tir: 1'b1};
    end else begin
      res_d = '{tx: sat16(sum_x), ty: sat16(sum_y), tz: sat16(sum_z), tir: 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      b1_k_q    <= k_d;
      b1_side_q <= side_i;
      b2_tx_q   <= b1_side_q.nx * b1_k_q;
      b2_ty_q   <= b1_side_q.ny * b1_k_q;
      b2_tz_q   <= b1_side_q.nz * b1_k_q;
      b2_mx_q   <= $signed({1'b0, b1_side_q.n}) * b1_side_q.ix;
      b2_my_q   <= $signed({1'b0, b1_side_q.n}) * b1_side_q.iy;
      b2_mz_q   <= $signed({1'b0, b1_side_q.n}) * b1_side_q.iz;
      b2_side_q <= b1_side_q;
      b3_res_q  <= res_d;
    end
  end

  assign valid_o = v_q[2];
  assign res_o   = b3_res_q;

endmodule

/* sv/refraction_vector_unit_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Refraction vector unit
// Snell refraction of an incident direction about a surface normal, with
// total internal reflection detection, in Q1.14 fixed point.
//
//   Channel   Direction  Handshake          Payload
//   request   in         valid_i / stall_o  normal_*_i, incident_*_i, index_ratio_i
//   result    out        valid_o / stall_i  refracted_*_o, total_reflection_o
//
// One request is taken every cycle while stall_o is low; each result passes
// 31 register stages on its way to the outputs: the 21-stage square root
// between six front and three back stages, plus the output register.
// Reset clears all valid bits; payload registers are not reset.
// A stalled result holds the output; one further result parks in a skid
// register, and stall_o is raised only while that register is full.
// ----------------------------------------------------------------------------
module refraction_vector_unit_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               stall_o,
  input  logic signed [15:0] normal_x_i,
  input  logic signed [15:0] normal_y_i,
  input  logic signed [15:0] normal_z_i,
  input  logic signed [15:0] incident_x_i,
  input  logic signed [15:0] incident_y_i,
  input  logic signed [15:0] incident_z_i,
  input  logic [15:0]        index_ratio_i,
  output logic               valid_o,
  input  logic               stall_i,
  output logic signed [15:0] refracted_x_o,
  output logic signed [15:0] refracted_y_o,
  output logic signed [15:0] refracted_z_o,
  output logic               total_reflection_o
);
  import rvu_pkg::*;

  logic    en;
  logic    fr_valid, sq_valid, bk_valid;
  logic [40:0] fr_rad;
  side_t   fr_side, sq_side;
  logic [20:0] sq_root;
  result_t bk_res;

  logic    out_v_q, skid_v_q;
  result_t out_q, skid_q;
  logic    out_free;

  assign en       = !skid_v_q;
  assign out_free = !out_v_q || !stall_i;

  rvu_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (valid_i),
    .nx_i    (normal_x_i),
    .ny_i    (normal_y_i),
    .nz_i    (normal_z_i),
    .ix_i    (incident_x_i),
    .iy_i    (incident_y_i),
    .iz_i    (incident_z_i),
    .n_i     (index_ratio_i),
    .valid_o (fr_valid),
    .rad_o   (fr_rad),
    .side_o  (fr_side)
  );

  rvu_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (fr_valid),
    .rad_i   (fr_rad),
    .side_i  (fr_side),
    .valid_o (sq_valid),
    .root_o  (sq_root),
    .side_o  (sq_side)
  );

  rvu_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (sq_valid),
    .root_i  (sq_root),
    .side_i  (sq_side),
    .valid_o (bk_valid),
    .res_o   (bk_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (out_free) begin
      if (skid_v_q) begin
        out_v_q  <= 1'b1;
        skid_v_q <= 1'b0;
      end else begin
        out_v_q <= bk_valid;
      end
    end else if (en && bk_valid) begin
      skid_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      out_q <= skid_v_q ? skid_q : bk_res;
    end else if (en && bk_valid) begin
      skid_q <= bk_res;
    end
  end

  assign stall_o            = skid_v_q;
  assign valid_o            = out_v_q;
  assign refracted_x_o      = out_q.tx;
  assign refracted_y_o      = out_q.ty;
  assign refracted_z_o      = out_q.tz;
  assign total_reflection_o = out_q.tir;

  a_skid_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> out_v_q)
    else $error("skid register full while output register empty");

  a_tir_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && total_reflection_o) |->
      (refracted_x_o == 16'sd0 && refracted_y_o == 16'sd0 && refracted_z_o == 16'sd0))
    else $error("total reflection result with non-zero direction");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(stall_o) |-> $past(valid_o && stall_i))
    else $error("request stall raised without a stalled result");

  a_skid_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (skid_v_q && !stall_i) |=> !skid_v_q)
    else $error("skid register not drained after output accepted");

endmodule
